// File: rtl/srw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srw_pkg: shared types and constants of the sequence-number reorder window
// Request and status codes, cell commands, controller states, default sizes.
// ----------------------------------------------------------------------------
package srw_pkg;

   // default sizes
   localparam int DEPTH_DEF     = 64;
   localparam int SEQ_BITS_DEF  = 16;
   localparam int BYTE_BITS_DEF = 24;

   // fixed port widths
   localparam int REQ_W      = 2;
   localparam int SEQ_PORT_W = 16;
   localparam int LEN_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int POS_PORT_W = 6;
   localparam int QCNT_W     = 7;
   localparam int RUN_W      = 16;
   localparam int MAXWIN_W   = 7;

   localparam logic [MAXWIN_W-1:0] MAXWIN_RESET = 7'd64;
   localparam logic [RUN_W-1:0]    RUN_MAX      = 16'hFFFF;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLR = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STS_ADDED   = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NEW     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_LATE    = 3'd2;
   localparam logic [STATUS_W-1:0] STS_EARLY   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_DEQ     = 3'd4;
   localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd5;
   localparam logic [STATUS_W-1:0] STS_CLEARED = 3'd6;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_ADD,
      CELL_APPEND
   } cell_op_type;

   // action decided at accept, carried out in the execute cycle
   typedef enum logic [2:0] {
      ACT_ADD,
      ACT_APPEND,
      ACT_LATE,
      ACT_EARLY,
      ACT_DEQ,
      ACT_EMPTY,
      ACT_CLEAR
   } act_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

// File: rtl/srw_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srw_cell: one slot of the reorder window chain
// Holds one frame slot; takes its neighbor's slot on a dequeue, or a write
// when the broadcast position or the gap range covers its own index.
// ----------------------------------------------------------------------------
module srw_cell
   import srw_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int INDEX     = 0,
   parameter int SEQ_BITS  = SEQ_BITS_DEF,
   parameter int BYTE_BITS = BYTE_BITS_DEF,
   localparam int IDX_W    = $clog2(DEPTH),
   localparam int CNT_W    = $clog2(DEPTH + 1)
) (
   input  wire                  clock,
   input  cell_op_type          op,
   input  wire [IDX_W-1:0]      wr_pos,
   input  wire [CNT_W-1:0]      wr_lo,
   input  wire [SEQ_BITS-1:0]   wr_seq,
   input  wire [BYTE_BITS-1:0]  wr_bytes,
   input  wire [SEQ_BITS-1:0]   nxt_seq,
   input  wire [BYTE_BITS-1:0]  nxt_bytes,
   input  wire                  nxt_filled,
   output logic [SEQ_BITS-1:0]  seq,
   output logic [BYTE_BITS-1:0] bytes,
   output logic                 filled
);

   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [BYTE_BITS-1:0] bytes_ff, bytes_in;
   logic                 filled_ff, filled_in;
   logic                 hit, in_gap;

   assign hit    = (wr_pos == IDX_W'(INDEX));
   assign in_gap = (CNT_W'(INDEX) >= wr_lo) && (IDX_W'(INDEX) < wr_pos);

   // slot update
   always_comb begin
      seq_in    = seq_ff;
      bytes_in  = bytes_ff;
      filled_in = filled_ff;
      unique case (op)
         CELL_HOLD: begin
         end
         CELL_SHIFT: begin
            seq_in    = nxt_seq;
            bytes_in  = nxt_bytes;
            filled_in = nxt_filled;
         end
         CELL_ADD: begin
            if (hit) begin
               seq_in    = wr_seq;
               bytes_in  = wr_bytes;
               filled_in = 1'b1;
            end
         end
         CELL_APPEND: begin
            if (hit) begin
               seq_in    = wr_seq;
               bytes_in  = wr_bytes;
               filled_in = 1'b1;
            end else if (in_gap) begin
               seq_in    = '0;
               bytes_in  = '0;
               filled_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      bytes_ff  <= bytes_in;
      filled_ff <= filled_in;
   end

   assign seq    = seq_ff;
   assign bytes  = bytes_ff;
   assign filled = filled_ff;

endmodule
`default_nettype wire

// File: rtl/seqnum_reorder_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seqnum_reorder_window: sequence-number reorder window of frame slots
// A chain of slot cells, position 0 at the head, plus a two-state controller
// that places fragments, appends gap slots, pops the head and clears.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   req_type, req_seq_num, req_payload_len       start / busy
//  result    rsp_status .. rsp_early_drops                rsp_valid strobe
//  config    csr_wdata (max_window)                       csr_we
//
//  For every item, the accept cycle works out the slot position
//  and the action, the execute cycle (busy high) updates the cell chain and
//  registers the result, which shows on the rsp_ ports for the next cycle.
//  A new item may be accepted in the cycle the result is shown.
//  Synchronous active-high reset empties the window; no clearing pass.
//  The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module seqnum_reorder_window
   import srw_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int SEQ_BITS  = SEQ_BITS_DEF,
   parameter int BYTE_BITS = BYTE_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire [REQ_W-1:0]       req_type,
   input  wire [SEQ_PORT_W-1:0]  req_seq_num,
   input  wire [LEN_W-1:0]       req_payload_len,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [POS_PORT_W-1:0] rsp_slot_pos,
   output logic [BYTE_BITS-1:0]  rsp_slot_total,
   output logic [SEQ_PORT_W-1:0] rsp_slot_seq,
   output logic                  rsp_slot_filled,
   output logic [QCNT_W-1:0]     rsp_queue_count,
   output logic [RUN_W-1:0]      rsp_late_drops,
   output logic [RUN_W-1:0]      rsp_early_drops,
   input  wire                   csr_we,
   input  wire [MAXWIN_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LIM_W = (CNT_W > MAXWIN_W) ? CNT_W : MAXWIN_W;
   localparam int POS_W = ((SEQ_BITS > LIM_W) ? SEQ_BITS : LIM_W) + 2;
   localparam int SUM_W = BYTE_BITS + 1;

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SEQ_BITS-1:0]  last_seq_ff, last_seq_in;
   logic                 known_ff, known_in;
   logic [RUN_W-1:0]     late_ff, late_in;
   logic [RUN_W-1:0]     early_ff, early_in;
   logic [MAXWIN_W-1:0]  max_window_ff;

   // item held for the execute cycle
   act_type              act_ff, act_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   logic [LEN_W-1:0]     len_ff, len_in;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [POS_PORT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [BYTE_BITS-1:0]  rsp_total_ff, rsp_total_in;
   logic [SEQ_PORT_W-1:0] rsp_seq_ff, rsp_seq_in;
   logic                  rsp_filled_ff, rsp_filled_in;

   // cell chain
   logic [SEQ_BITS-1:0]  cell_seq    [DEPTH];
   logic [BYTE_BITS-1:0] cell_bytes  [DEPTH];
   logic                 cell_filled [DEPTH];
   cell_op_type          cell_op;
   logic [SEQ_BITS-1:0]  wr_seq;
   logic [BYTE_BITS-1:0] wr_bytes;

   // accept-cycle decode
   logic                 accept;
   logic [LIM_W-1:0]     limit;
   logic [POS_W-1:0]     pos_full;
   logic [SEQ_BITS-1:0]  seq_req;

   // touched-slot readout
   logic [SEQ_BITS-1:0]  rd_seq;
   logic [BYTE_BITS-1:0] rd_bytes;
   logic                 rd_filled;
   logic [SUM_W-1:0]     add_sum;
   logic [BYTE_BITS-1:0] add_bytes;
   logic [BYTE_BITS-1:0] len_bytes;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff == ST_EXEC);
   assign seq_req = SEQ_BITS'(req_seq_num);

   // window limit, clamped to 1..DEPTH
   always_comb begin
      if (max_window_ff == '0) begin
         limit = LIM_W'(1);
      end else if (LIM_W'(max_window_ff) > LIM_W'(DEPTH)) begin
         limit = LIM_W'(DEPTH);
      end else begin
         limit = LIM_W'(max_window_ff);
      end
   end

   // target position relative to head; sign bit flags a late fragment
   assign pos_full = known_ff
      ? (POS_W'(seq_req) - POS_W'(last_seq_ff) + POS_W'(count_ff) - POS_W'(1))
      : '0;

   // read the touched slot: one-hot select over the chain
   always_comb begin
      rd_seq    = '0;
      rd_bytes  = '0;
      rd_filled = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pos_ff == IDX_W'(i)) begin
            rd_seq    = rd_seq | cell_seq[i];
            rd_bytes  = rd_bytes | cell_bytes[i];
            rd_filled = rd_filled | cell_filled[i];
         end
      end
   end

   // saturating byte totals
   assign len_bytes = BYTE_BITS'(len_ff);
   assign add_sum   = SUM_W'(rd_bytes) + SUM_W'(len_ff);
   assign add_bytes = add_sum[BYTE_BITS] ? {BYTE_BITS{1'b1}} : add_sum[BYTE_BITS-1:0];

   // controller: next state, decode at accept, execute
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_seq_in   = last_seq_ff;
      known_in      = known_ff;
      late_in       = late_ff;
      early_in      = early_ff;
      act_in        = act_ff;
      pos_in        = pos_ff;
      seq_in        = seq_ff;
      len_in        = len_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_filled_in = rsp_filled_ff;
      cell_op       = CELL_HOLD;
      wr_seq        = seq_ff;
      wr_bytes      = len_bytes;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               pos_in   = IDX_W'(pos_full);
               seq_in   = seq_req;
               len_in   = req_payload_len;
               priority if (req_type == REQ_ENQ) begin
                  priority if (pos_full[POS_W-1]) begin
                     act_in = ACT_LATE;
                  end else if (pos_full >= POS_W'(limit)) begin
                     act_in = ACT_EARLY;
                  end else if (pos_full < POS_W'(count_ff)) begin
                     act_in = ACT_ADD;
                  end else begin
                     act_in = ACT_APPEND;
                  end
               end else if (req_type == REQ_DEQ) begin
                  act_in = (count_ff != '0) ? ACT_DEQ : ACT_EMPTY;
               end else if (req_type == REQ_CLR) begin
                  act_in = ACT_CLEAR;
               end else begin
                  act_in = ACT_EMPTY;
               end
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_pos_in    = '0;
            rsp_total_in  = '0;
            rsp_seq_in    = '0;
            rsp_filled_in = 1'b0;
            unique case (act_ff)
               ACT_ADD: begin
                  cell_op       = CELL_ADD;
                  wr_seq        = rd_filled ? rd_seq : seq_ff;
                  wr_bytes      = add_bytes;
                  late_in       = '0;
                  early_in      = '0;
                  rsp_status_in = STS_ADDED;
                  rsp_pos_in    = POS_PORT_W'(pos_ff);
                  rsp_total_in  = add_bytes;
                  rsp_seq_in    = SEQ_PORT_W'(wr_seq);
                  rsp_filled_in = 1'b1;
               end
               ACT_APPEND: begin
                  cell_op       = CELL_APPEND;
                  count_in      = CNT_W'(pos_ff) + CNT_W'(1);
                  last_seq_in   = seq_ff;
                  known_in      = 1'b1;
                  late_in       = '0;
                  early_in      = '0;
                  rsp_status_in = STS_NEW;
                  rsp_pos_in    = POS_PORT_W'(pos_ff);
                  rsp_total_in  = len_bytes;
                  rsp_seq_in    = SEQ_PORT_W'(seq_ff);
                  rsp_filled_in = 1'b1;
               end
               ACT_LATE: begin
                  if (late_ff != RUN_MAX) begin
                     late_in = late_ff + RUN_W'(1);
                  end
                  rsp_status_in = STS_LATE;
               end
               ACT_EARLY: begin
                  if (early_ff != RUN_MAX) begin
                     early_in = early_ff + RUN_W'(1);
                  end
                  rsp_status_in = STS_EARLY;
               end
               ACT_DEQ: begin
                  cell_op       = CELL_SHIFT;
                  count_in      = count_ff - CNT_W'(1);
                  rsp_status_in = STS_DEQ;
                  rsp_total_in  = cell_bytes[0];
                  rsp_seq_in    = SEQ_PORT_W'(cell_seq[0]);
                  rsp_filled_in = cell_filled[0];
               end
               ACT_CLEAR: begin
                  count_in      = '0;
                  last_seq_in   = '0;
                  known_in      = 1'b0;
                  late_in       = '0;
                  early_in      = '0;
                  rsp_status_in = STS_CLEARED;
               end
               ACT_EMPTY: begin
                  rsp_status_in = STS_EMPTY;
               end
               default: begin
                  rsp_status_in = STS_EMPTY;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         last_seq_ff   <= '0;
         known_ff      <= 1'b0;
         late_ff       <= '0;
         early_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         max_window_ff <= MAXWIN_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_seq_ff  <= last_seq_in;
         known_ff     <= known_in;
         late_ff      <= late_in;
         early_ff     <= early_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_window_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pos_ff        <= pos_in;
      seq_ff        <= seq_in;
      len_ff        <= len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_filled_ff <= rsp_filled_in;
   end

   // slot chain; the last cell shifts in its own contents
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int NXT = (g == DEPTH - 1) ? g : g + 1;
      srw_cell #(
         .DEPTH     (DEPTH),
         .INDEX     (g),
         .SEQ_BITS  (SEQ_BITS),
         .BYTE_BITS (BYTE_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .wr_pos     (pos_ff),
         .wr_lo      (count_ff),
         .wr_seq     (wr_seq),
         .wr_bytes   (wr_bytes),
         .nxt_seq    (cell_seq[NXT]),
         .nxt_bytes  (cell_bytes[NXT]),
         .nxt_filled (cell_filled[NXT]),
         .seq        (cell_seq[g]),
         .bytes      (cell_bytes[g]),
         .filled     (cell_filled[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_pos    = rsp_pos_ff;
   assign rsp_slot_total  = rsp_total_ff;
   assign rsp_slot_seq    = rsp_seq_ff;
   assign rsp_slot_filled = rsp_filled_ff;
   assign rsp_queue_count = QCNT_W'(count_ff);
   assign rsp_late_drops  = late_ff;
   assign rsp_early_drops = early_ff;

   // execute is followed by idle in the next cycle
   a_exec_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("execute cycle did not end");

   // an accepted item enters execute
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item not executed");

   // exactly one result strobe per execute cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(busy))
      else $error("result strobe not tied to execute");

   // window never holds more slots than the chain has cells
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("slot count above depth");

endmodule
`default_nettype wire

// File: verif/srw_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srw_result_checker: result checker for the sequence-number reorder window
// Watches the request, result and register ports and keeps its own copy of
// the slot window. Every accepted item yields one predicted result, and each
// result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module srw_result_checker
   import srw_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire                     busy,
   input  wire [REQ_W-1:0]         req_type,
   input  wire [SEQ_PORT_W-1:0]    req_seq_num,
   input  wire [LEN_W-1:0]         req_payload_len,
   input  wire                     rsp_valid,
   input  wire [STATUS_W-1:0]      rsp_status,
   input  wire [POS_PORT_W-1:0]    rsp_slot_pos,
   input  wire [BYTE_BITS_DEF-1:0] rsp_slot_total,
   input  wire [SEQ_PORT_W-1:0]    rsp_slot_seq,
   input  wire                     rsp_slot_filled,
   input  wire [QCNT_W-1:0]        rsp_queue_count,
   input  wire [RUN_W-1:0]         rsp_late_drops,
   input  wire [RUN_W-1:0]         rsp_early_drops,
   input  wire                     csr_we,
   input  wire [MAXWIN_W-1:0]      csr_wdata,
   output int                      fail_count,
   output int                      pending
);

   typedef struct packed {
      logic [SEQ_PORT_W-1:0]    seq;
      logic [BYTE_BITS_DEF-1:0] bytes;
      logic                     filled;
   } frame_slot_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [POS_PORT_W-1:0]    pos;
      logic [BYTE_BITS_DEF-1:0] total;
      logic [SEQ_PORT_W-1:0]    seq;
      logic                     filled;
      logic [QCNT_W-1:0]        qcount;
      logic [RUN_W-1:0]         late;
      logic [RUN_W-1:0]         early;
   } window_result_type;

   // window contents, head first, and the results still owed by the block
   frame_slot_type    window_slots[$];
   window_result_type owed_results[$];

   logic [MAXWIN_W-1:0]   max_window;
   logic [SEQ_PORT_W-1:0] last_seq;
   logic                  seq_known;
   logic [RUN_W-1:0]      late_run;
   logic [RUN_W-1:0]      early_run;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // register value as used: 0 acts as 1, anything above the depth as the depth
   function automatic int window_limit();
      if (max_window == '0)
         return 1;
      if (max_window > DEPTH_DEF)
         return DEPTH_DEF;
      return int'(max_window);
   endfunction

   // tail append; the head falls out when the window would overflow
   function automatic void push_slot(frame_slot_type s);
      window_slots.insert(window_slots.size(), s);
      if (window_slots.size() > window_limit())
         window_slots.delete(0);
   endfunction

   // next window state and the result one item produces
   function automatic window_result_type apply_request(logic [REQ_W-1:0] kind,
                                                       logic [SEQ_PORT_W-1:0] seq,
                                                       logic [LEN_W-1:0] len);
      window_result_type      r;
      frame_slot_type         s;
      logic [BYTE_BITS_DEF:0] sum;
      int                     pos;
      int                     gaps;
      r = '0;
      r.status = STS_EMPTY;
      if (kind == REQ_ENQ) begin
         pos = 0;
         if (seq_known)
            pos = int'(seq) - int'(last_seq) + window_slots.size() - 1;
         if (pos < 0) begin
            r.status = STS_LATE;
            if (late_run != RUN_MAX)
               late_run++;
         end else if (pos >= window_limit()) begin
            r.status = STS_EARLY;
            if (early_run != RUN_MAX)
               early_run++;
         end else begin
            late_run  = '0;
            early_run = '0;
            if (pos < window_slots.size()) begin
               // fragment of a slot already in the window
               s = window_slots[pos];
               if (!s.filled) begin
                  s.filled = 1'b1;
                  s.seq    = seq;
               end
               sum = (BYTE_BITS_DEF + 1)'(s.bytes) + (BYTE_BITS_DEF + 1)'(len);
               s.bytes = sum[BYTE_BITS_DEF] ? '1 : sum[BYTE_BITS_DEF-1:0];
               window_slots[pos] = s;
               r.status = STS_ADDED;
               r.pos    = POS_PORT_W'(pos);
               r.total  = s.bytes;
               r.seq    = s.seq;
               r.filled = 1'b1;
            end else begin
               // gap slots first, then the new frame
               gaps = pos - window_slots.size();
               for (int i = 0; i < gaps; i++)
                  push_slot('0);
               s.seq    = seq;
               s.bytes  = BYTE_BITS_DEF'(len);
               s.filled = 1'b1;
               push_slot(s);
               last_seq  = seq;
               seq_known = 1'b1;
               r.status = STS_NEW;
               r.pos    = POS_PORT_W'(window_slots.size() - 1);
               r.total  = s.bytes;
               r.seq    = seq;
               r.filled = 1'b1;
            end
         end
      end else if (kind == REQ_DEQ) begin
         if (window_slots.size() > 0) begin
            s = window_slots[0];
            window_slots.delete(0);
            r.status = STS_DEQ;
            r.total  = s.bytes;
            r.seq    = s.seq;
            r.filled = s.filled;
         end
      end else if (kind == REQ_CLR) begin
         window_slots.delete();
         last_seq  = '0;
         seq_known = 1'b0;
         late_run  = '0;
         early_run = '0;
         r.status  = STS_CLEARED;
      end
      r.qcount = QCNT_W'(window_slots.size());
      r.late   = late_run;
      r.early  = early_run;
      return r;
   endfunction

   task automatic check_field(string name, logic [BYTE_BITS_DEF-1:0] want,
                              logic [BYTE_BITS_DEF-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // compare outgoing results first, then predict the item taken at this edge
   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         window_slots.delete();
         owed_results.delete();
         max_window = MAXWIN_RESET;
         last_seq   = '0;
         seq_known  = 1'b0;
         late_run   = '0;
         early_run  = '0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
               $error("result strobe with no item outstanding");
               fail_count++;
            end else begin
               want = owed_results[0];
               owed_results.delete(0);
               check_field("status", BYTE_BITS_DEF'(want.status),
                           BYTE_BITS_DEF'(rsp_status));
               check_field("slot_pos", BYTE_BITS_DEF'(want.pos),
                           BYTE_BITS_DEF'(rsp_slot_pos));
               check_field("slot_total", want.total, rsp_slot_total);
               check_field("slot_seq", BYTE_BITS_DEF'(want.seq),
                           BYTE_BITS_DEF'(rsp_slot_seq));
               check_field("slot_filled", BYTE_BITS_DEF'(want.filled),
                           BYTE_BITS_DEF'(rsp_slot_filled));
               check_field("queue_count", BYTE_BITS_DEF'(want.qcount),
                           BYTE_BITS_DEF'(rsp_queue_count));
               check_field("late_drops", BYTE_BITS_DEF'(want.late),
                           BYTE_BITS_DEF'(rsp_late_drops));
               check_field("early_drops", BYTE_BITS_DEF'(want.early),
                           BYTE_BITS_DEF'(rsp_early_drops));
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            owed_results.insert(owed_results.size(),
                                apply_request(req_type, req_seq_num,
                                              req_payload_len));
         if (csr_we === 1'b1)
            max_window = csr_wdata;
      end
      pending = owed_results.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sequence-number reorder window
// Drives a directed run over the special cases, then random phases under
// several window sizes and sender idle rates; a checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import srw_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [MAXWIN_W-1:0] WINDOW_PLAN [8] =
      '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd64, 7'd33, 7'd2};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [REQ_W-1:0]         req_type = '0;
   logic [SEQ_PORT_W-1:0]    req_seq_num = '0;
   logic [LEN_W-1:0]         req_payload_len = '0;
   logic                     csr_we = 1'b0;
   logic [MAXWIN_W-1:0]      csr_wdata = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [POS_PORT_W-1:0]    rsp_slot_pos;
   logic [BYTE_BITS_DEF-1:0] rsp_slot_total;
   logic [SEQ_PORT_W-1:0]    rsp_slot_seq;
   logic                     rsp_slot_filled;
   logic [QCNT_W-1:0]        rsp_queue_count;
   logic [RUN_W-1:0]         rsp_late_drops;
   logic [RUN_W-1:0]         rsp_early_drops;
   int                       fail_count;
   int                       pending;

   // rough view of the window, only to aim sequence numbers at it
   int idle_pct = 0;
   bit win_known = 1'b0;
   int head_seq = 0;
   int win_cnt = 0;
   int win_lim = DEPTH_DEF;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   seqnum_reorder_window u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_seq_num     (req_seq_num),
      .req_payload_len (req_payload_len),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_pos    (rsp_slot_pos),
      .rsp_slot_total  (rsp_slot_total),
      .rsp_slot_seq    (rsp_slot_seq),
      .rsp_slot_filled (rsp_slot_filled),
      .rsp_queue_count (rsp_queue_count),
      .rsp_late_drops  (rsp_late_drops),
      .rsp_early_drops (rsp_early_drops),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   srw_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_seq_num     (req_seq_num),
      .req_payload_len (req_payload_len),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_pos    (rsp_slot_pos),
      .rsp_slot_total  (rsp_slot_total),
      .rsp_slot_seq    (rsp_slot_seq),
      .rsp_slot_filled (rsp_slot_filled),
      .rsp_queue_count (rsp_queue_count),
      .rsp_late_drops  (rsp_late_drops),
      .rsp_early_drops (rsp_early_drops),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // one item: optional idle gap, then hold start until the block takes it
   task automatic send_item(logic [REQ_W-1:0] kind, logic [SEQ_PORT_W-1:0] seq,
                            logic [LEN_W-1:0] len);
      int gap;
      int pos;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 12)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_seq_num     <= seq;
      req_payload_len <= len;
      do @(posedge clock); while (busy !== 1'b0);
      // follow the head so later items land in, before or past the window
      case (kind)
         REQ_ENQ: begin
            if (!win_known) begin
               win_known = 1'b1;
               head_seq  = seq;
               win_cnt   = 1;
            end else begin
               pos = int'(seq) - head_seq;
               if (pos >= win_cnt && pos < win_lim)
                  win_cnt = pos + 1;
            end
         end
         REQ_DEQ: begin
            if (win_cnt > 0) begin
               win_cnt--;
               head_seq++;
            end
         end
         REQ_CLR: begin
            win_known = 1'b0;
            win_cnt   = 0;
         end
         default: ;
      endcase
   endtask

   // hold off until the checker owes nothing
   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_window(logic [MAXWIN_W-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we  <= 1'b0;
      win_lim = (value == '0) ? 1 : (value > DEPTH_DEF) ? DEPTH_DEF : int'(value);
   endtask

   // mostly in-window fragments, some late, some early, some noise
   task automatic random_item();
      int               roll;
      int               s;
      logic [REQ_W-1:0] kind;
      logic [LEN_W-1:0] len;
      case ($urandom_range(9))
         0:       len = '0;
         1:       len = '1;
         2, 3:    len = LEN_W'($urandom);
         default: len = LEN_W'($urandom_range(1500));
      endcase
      roll = $urandom_range(99);
      if (win_known && head_seq > 65535 - 2 * win_lim - 8)
         kind = REQ_CLR;
      else if (roll < 3)
         kind = REQ_CLR;
      else if (roll < 5)
         kind = REQ_UNUSED;
      else if (roll < ((win_cnt >= win_lim) ? 50 : 23))
         kind = REQ_DEQ;
      else
         kind = REQ_ENQ;
      roll = $urandom_range(99);
      if (!win_known)
         s = (roll < 90) ? int'($urandom_range(40000)) : int'($urandom_range(65535));
      else if (roll < 75)
         s = head_seq + int'($urandom_range(win_lim - 1));
      else if (roll < 85)
         s = head_seq - 1 - int'($urandom_range(3));
      else if (roll < 95)
         s = head_seq + win_lim + int'($urandom_range(3));
      else
         s = int'($urandom_range(65535));
      if (s < 0)
         s = 0;
      else if (s > 65535)
         s = 65535;
      send_item(kind, SEQ_PORT_W'(s), len);
   endtask

   initial begin
      int ph;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty window, ignored request, gaps, drops, dequeues, clear
      send_item(REQ_DEQ, '0, '0);
      send_item(REQ_UNUSED, 16'd5, 16'd5);
      send_item(REQ_ENQ, 16'd100, 16'd10);
      send_item(REQ_ENQ, 16'd103, 16'd0);
      send_item(REQ_ENQ, 16'd101, 16'd5);
      send_item(REQ_ENQ, 16'd101, 16'd7);
      send_item(REQ_ENQ, 16'd99, 16'd1);
      send_item(REQ_ENQ, 16'd98, 16'd1);
      send_item(REQ_ENQ, 16'd164, 16'd1);
      send_item(REQ_ENQ, 16'd163, 16'd3);
      send_item(REQ_DEQ, '0, '0);
      send_item(REQ_DEQ, '0, '0);
      send_item(REQ_DEQ, '0, '0);
      send_item(REQ_CLR, '1, '1);
      send_item(REQ_ENQ, 16'h0000, 16'h0000);
      send_item(REQ_ENQ, 16'hFFFF, 16'd1);
      send_item(REQ_ENQ, 16'h0000, 16'hFFFF);
      send_item(REQ_CLR, '0, '0);
      send_item(REQ_ENQ, 16'hFFFF, 16'hFFFF);
      send_item(REQ_ENQ, 16'h0000, 16'd1);
      send_item(REQ_UNUSED, '1, '1);
      send_item(REQ_DEQ, '1, '1);
      send_item(REQ_DEQ, '0, '0);

      // random phases, one window setting each
      for (ph = 0; ph < 8; ph++) begin
         write_window(WINDOW_PLAN[ph]);
         idle_pct = (ph < 3) ? 22 : (ph < 6) ? 76 : 0;
         if (ph == 2) begin
            // drive one slot to its byte ceiling
            send_item(REQ_CLR, '0, '0);
            repeat (260) send_item(REQ_ENQ, 16'd1000, 16'hFFFF);
         end
         repeat (145) random_item();
      end

      wait_drained();
      repeat (4) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // hang guard
   initial begin
      #(5_000_000);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
